// ===== sv/color_ramp_lookup_assert.svh =====
// Assertion macros for the color ramp lookup block.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef COLOR_RAMP_LOOKUP_ASSERT_SVH
`define COLOR_RAMP_LOOKUP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CRL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("color ramp lookup assertion failed");

// Next-cycle implication, off during reset.
`define CRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("color ramp lookup assertion failed");

`endif

// ===== sv/crl_pkg.sv =====
// Shared types and constants of the color ramp lookup block.
// No dependencies.
package crl_pkg;

  localparam int KeyW = 16;
  localparam int ChW  = 8;
  localparam int NCh  = 4;
  localparam int ColW = NCh * ChW;
  localparam int NumW = 24;
  localparam int QuoW = 8;

  localparam logic [1:0] CfgMode    = 2'd0;
  localparam logic [1:0] CfgCount   = 2'd1;
  localparam logic [1:0] CfgDefault = 2'd2;

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdLookup = 1'b1;

  typedef logic [NCh-1:0][ChW-1:0] crl_color_t;

  typedef struct packed {
    logic dflt;
    logic interp;
  } crl_sel_t;

  typedef struct packed {
    logic [NCh-1:0][NumW-1:0] rem;
    logic [NCh-1:0][QuoW-1:0] quo;
    logic [NCh-1:0]           neg;
    logic [KeyW-1:0]          delta;
    crl_color_t               base;
    logic                     dflt;
  } crl_div_t;

endpackage

// ===== sv/crl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crl_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/crl_search.sv =====
// Key register file and parallel key compare of the color ramp lookup.
// Depends on crl_pkg.
module crl_search #(
  parameter int MaxEntries = 8
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [$clog2(MaxEntries)-1:0]         wr_addr_i,
  input  logic signed [crl_pkg::KeyW-1:0]       wr_key_i,
  input  logic signed [crl_pkg::KeyW-1:0]       value_i,
  input  logic                                  present_i,
  input  logic [3:0]                            count_i,
  input  logic                                  mode_i,
  output crl_pkg::crl_sel_t                     sel_o,
  output logic [$clog2(MaxEntries)-1:0]         prev_o,
  output logic [$clog2(MaxEntries)-1:0]         next_o
);

  localparam int IW = $clog2(MaxEntries);
  localparam int CW = $clog2(MaxEntries + 1);

  logic signed [crl_pkg::KeyW-1:0] key_q [MaxEntries];
  logic [CW-1:0] n;
  logic [CW-1:0] idx;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_q[wr_addr_i] <= wr_key_i;
    end
  end

  always_comb begin
    n = (8'(count_i) > 8'(MaxEntries)) ? CW'(MaxEntries) : CW'(count_i);
    // first entry in use whose key exceeds the value, else n
    idx = n;
    for (int j = MaxEntries - 1; j >= 0; j--) begin
      if ((CW'(j) < n) && (key_q[j] > value_i)) begin
        idx = CW'(j);
      end
    end
    sel_o.dflt   = !present_i || (n == '0);
    sel_o.interp = mode_i && (idx != '0) && (idx != n);
    prev_o = (idx == '0) ? '0 : IW'(idx - 1'b1);
    next_o = (idx == n) ? prev_o : IW'(idx);
  end

endmodule

// ===== sv/crl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, four channels.
// Depends on crl_pkg.
module crl_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  crl_pkg::crl_div_t data_i,
  output logic              valid_o,
  output crl_pkg::crl_div_t data_o
);

  localparam int NStg = crl_pkg::QuoW;

  logic              vld_q [NStg];
  crl_pkg::crl_div_t stg_q [NStg];
  crl_pkg::crl_div_t stg_d [NStg];

  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      logic [crl_pkg::NumW-1:0] shifted;
      stg_d[k] = (k == 0) ? data_i : stg_q[(k == 0) ? 0 : k - 1];
      shifted  = crl_pkg::NumW'(stg_d[k].delta) << (NStg - 1 - k);
      for (int c = 0; c < crl_pkg::NCh; c++) begin
        if (stg_d[k].rem[c] >= shifted) begin
          stg_d[k].rem[c] = stg_d[k].rem[c] - shifted;
          stg_d[k].quo[c][NStg-1-k] = 1'b1;
        end else begin
          stg_d[k].quo[c][NStg-1-k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NStg; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (adv_i) begin
      for (int k = 0; k < NStg; k++) begin
        vld_q[k] <= (k == 0) ? valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NStg; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign data_o  = stg_q[NStg-1];

endmodule

// ===== sv/color_ramp_lookup.sv =====
// Color ramp lookup: maps a signed Q1.15 value to RGBA through a table of key/color
// entries, gradient or stepwise. Depends on crl_pkg, crl_search, crl_ram, crl_div.
//
// Usage: one item is taken every cycle while in_stall_o is low; a lookup's result passes
// through 13 register stages (key compare at the transfer, table read, difference,
// multiply, eight divider stages, output). Write items load the table at their transfer
// and give no result. The whole pipeline holds while a result waits on the output, so
// in_stall_o follows out_stall_i then. The user must write configuration only while no
// lookup is in flight; the block itself does not enforce it.
module color_ramp_lookup #(
  parameter int MaxEntries = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [2:0]  entry_slot_i,
  input  logic signed [15:0] entry_key_i,
  input  logic [7:0]  entry_red_i,
  input  logic [7:0]  entry_green_i,
  input  logic [7:0]  entry_blue_i,
  input  logic [7:0]  entry_alpha_i,
  input  logic signed [15:0] lookup_value_i,
  input  logic        value_present_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  output logic        from_default_o
);

  localparam int IW = $clog2(MaxEntries);
  localparam int EW = crl_pkg::KeyW + crl_pkg::ColW;

  logic        mode_q;
  logic [3:0]  count_q;
  logic [31:0] dflt_q;

  logic adv;
  logic accept;
  logic wr_en;
  logic [IW-1:0] wr_addr;

  crl_pkg::crl_sel_t sel;
  logic [IW-1:0] prev_idx, next_idx;

  // stage 1: search result, read issue
  logic          s1_valid_q;
  logic          s1_dflt_q, s1_interp_q;
  logic signed [15:0] s1_x_q;
  logic [IW-1:0] s1_prev_q, s1_next_q;

  // stage 2: table data
  logic          s2_valid_q;
  logic          s2_dflt_q, s2_interp_q;
  logic signed [15:0] s2_x_q;
  logic [EW-1:0] rd_prev, rd_next;

  // stage 3: offsets and channel differences
  logic          s3_valid_q;
  logic [crl_pkg::NCh-1:0][7:0] s3_mag_q;
  logic [crl_pkg::NCh-1:0]      s3_neg_q;
  logic [15:0]   s3_off_q, s3_delta_q;
  crl_pkg::crl_color_t s3_base_q;
  logic          s3_dflt_q;

  logic [crl_pkg::NCh-1:0][7:0] s3_mag_d;
  logic [crl_pkg::NCh-1:0]      s3_neg_d;
  logic [15:0]   s3_off_d, s3_delta_d;
  crl_pkg::crl_color_t s3_base_d;

  // stage 4: products into the divider
  logic              s4_valid_q;
  crl_pkg::crl_div_t s4_q;
  crl_pkg::crl_div_t s4_d;

  logic              dv_valid;
  crl_pkg::crl_div_t dv_data;

  logic                out_valid_q;
  crl_pkg::crl_color_t out_col_q, out_col_d;
  logic                out_dflt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b1;
      count_q <= 4'd0;
      dflt_q  <= 32'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        crl_pkg::CfgMode:    mode_q  <= cfg_data_i[0];
        crl_pkg::CfgCount:   count_q <= cfg_data_i[3:0];
        crl_pkg::CfgDefault: dflt_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold the whole pipe while a result waits
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign wr_en      = accept && (cmd_i == crl_pkg::CmdWrite) &&
                      (8'(entry_slot_i) < 8'(MaxEntries));
  assign wr_addr    = IW'(entry_slot_i);

  crl_search #(.MaxEntries(MaxEntries)) u_search (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_key_i  (entry_key_i),
    .value_i   (lookup_value_i),
    .present_i (value_present_i),
    .count_i   (count_q),
    .mode_i    (mode_q),
    .sel_o     (sel),
    .prev_o    (prev_idx),
    .next_o    (next_idx)
  );

  crl_ram #(.Width(EW), .Depth(MaxEntries)) u_ram_prev (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i ({entry_key_i, entry_red_i, entry_green_i, entry_blue_i, entry_alpha_i}),
    .re_i    (adv),
    .raddr_i (s1_prev_q),
    .rdata_o (rd_prev)
  );

  crl_ram #(.Width(EW), .Depth(MaxEntries)) u_ram_next (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i ({entry_key_i, entry_red_i, entry_green_i, entry_blue_i, entry_alpha_i}),
    .re_i    (adv),
    .raddr_i (s1_next_q),
    .rdata_o (rd_next)
  );

  always_comb begin
    logic signed [16:0] off_s, delta_s;
    crl_pkg::crl_color_t cp, cn;
    logic [8:0] diff;
    off_s   = $signed({s2_x_q[15], s2_x_q}) - $signed({rd_prev[EW-1], rd_prev[EW-1 -: 16]});
    delta_s = $signed({rd_next[EW-1], rd_next[EW-1 -: 16]}) -
              $signed({rd_prev[EW-1], rd_prev[EW-1 -: 16]});
    cp = rd_prev[crl_pkg::ColW-1:0];
    cn = rd_next[crl_pkg::ColW-1:0];
    s3_off_d   = s2_interp_q ? off_s[15:0] : 16'd0;
    s3_delta_d = s2_interp_q ? delta_s[15:0] : 16'd1;
    s3_base_d  = s2_dflt_q ? crl_pkg::crl_color_t'(dflt_q) : cp;
    for (int c = 0; c < crl_pkg::NCh; c++) begin
      diff        = {1'b0, cn[c]} - {1'b0, cp[c]};
      s3_neg_d[c] = s2_interp_q && diff[8];
      s3_mag_d[c] = !s2_interp_q ? 8'd0 : (diff[8] ? 8'(-diff) : diff[7:0]);
    end
  end

  always_comb begin
    s4_d.delta = s3_delta_q;
    s4_d.base  = s3_base_q;
    s4_d.dflt  = s3_dflt_q;
    s4_d.neg   = s3_neg_q;
    s4_d.quo   = '0;
    for (int c = 0; c < crl_pkg::NCh; c++) begin
      s4_d.rem[c] = s3_mag_q[c] * s3_off_q;
    end
  end

  crl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s4_valid_q),
    .data_i  (s4_q),
    .valid_o (dv_valid),
    .data_o  (dv_data)
  );

  always_comb begin
    for (int c = 0; c < crl_pkg::NCh; c++) begin
      out_col_d[c] = dv_data.neg[c] ? dv_data.base[c] - dv_data.quo[c]
                                    : dv_data.base[c] + dv_data.quo[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= accept && (cmd_i == crl_pkg::CmdLookup);
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dflt_q   <= sel.dflt;
      s1_interp_q <= sel.interp && !sel.dflt;
      s1_x_q      <= lookup_value_i;
      s1_prev_q   <= prev_idx;
      s1_next_q   <= next_idx;
      s2_dflt_q   <= s1_dflt_q;
      s2_interp_q <= s1_interp_q;
      s2_x_q      <= s1_x_q;
      s3_mag_q    <= s3_mag_d;
      s3_neg_q    <= s3_neg_d;
      s3_off_q    <= s3_off_d;
      s3_delta_q  <= s3_delta_d;
      s3_base_q   <= s3_base_d;
      s3_dflt_q   <= s2_dflt_q;
      s4_q        <= s4_d;
      out_col_q   <= out_col_d;
      out_dflt_q  <= dv_data.dflt;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_red_o      = out_col_q[3];
  assign out_green_o    = out_col_q[2];
  assign out_blue_o     = out_col_q[1];
  assign out_alpha_o    = out_col_q[0];
  assign from_default_o = out_dflt_q;

`include "color_ramp_lookup_assert.svh"

  `CRL_ASSERT_SAME(a_default_color, out_valid_o && from_default_o,
                   {out_red_o, out_green_o, out_blue_o, out_alpha_o} == dflt_q)
  `CRL_ASSERT_SAME(a_quotient_fits, s4_valid_q,
                   (s4_q.rem[0] < {s4_q.delta, 8'd0}) && (s4_q.rem[1] < {s4_q.delta, 8'd0}) &&
                   (s4_q.rem[2] < {s4_q.delta, 8'd0}) && (s4_q.rem[3] < {s4_q.delta, 8'd0}))
  `CRL_ASSERT_NEXT(a_hold_on_stall, s1_valid_q && !adv, s1_valid_q)

endmodule

// ===== sim/color_ramp_lookup_tb.sv =====
// Self-checking testbench for color_ramp_lookup: random and directed table loads
// and lookups, checked against an in-bench color predictor. Depends on crl_pkg.
module color_ramp_lookup_tb;

  localparam int NumSlots = 8;
  localparam int Latency  = 13;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] red, green, blue, alpha;
    logic       dflt;
  } color_res_t;

  class ramp_scoreboard;
    logic               mode;
    logic [3:0]         count;
    logic [31:0]        dflt_color;
    logic signed [15:0] keys [NumSlots];
    logic [31:0]        colors [NumSlots];
    color_res_t         pending [$];
    int                 mismatches;

    function new();
      mode = 1'b1; count = 0; dflt_color = 0; mismatches = 0;
      foreach (keys[s]) begin
        keys[s] = 0; colors[s] = 0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        crl_pkg::CfgMode:    mode = data[0];
        crl_pkg::CfgCount:   count = data[3:0];
        crl_pkg::CfgDefault: dflt_color = data;
        default: ;
      endcase
    endfunction

    function color_res_t unpack(logic [31:0] c, logic d);
      color_res_t r;
      r.red = c[31:24]; r.green = c[23:16]; r.blue = c[15:8]; r.alpha = c[7:0];
      r.dflt = d;
      return r;
    endfunction

    function void note_input(logic cmd, logic [2:0] slot, logic signed [15:0] key,
                             logic [31:0] col, logic signed [15:0] val, logic present);
      int n, i;
      longint p1, delta, off, v1, v2, q;
      logic [31:0] lo, hi, mix;
      if (cmd == crl_pkg::CmdWrite) begin
        keys[slot] = key; colors[slot] = col;
        return;
      end
      n = (count > NumSlots) ? NumSlots : count;
      if (!present || n == 0) begin
        pending.push_back(unpack(dflt_color, 1'b1));
        return;
      end
      for (i = 0; i < n; i++) if (keys[i] > val) break;
      if (i == 0) pending.push_back(unpack(colors[0], 1'b0));
      else if (i == n) pending.push_back(unpack(colors[n-1], 1'b0));
      else if (!mode) pending.push_back(unpack(colors[i-1], 1'b0));
      else begin
        lo = colors[i-1]; hi = colors[i];
        p1 = keys[i-1];
        delta = longint'(keys[i]) - p1;
        off = longint'(val) - p1;
        for (int c = 0; c < 4; c++) begin
          v1 = lo[31-8*c -: 8]; v2 = hi[31-8*c -: 8];
          q = ((v2 - v1) * off) / delta;
          mix[31-8*c -: 8] = 8'(v1 + q);
        end
        pending.push_back(unpack(mix, 1'b0));
      end
    endfunction

    function void check_result(color_res_t got);
      color_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, in_stall_o;
  logic cmd_i = 1'b0, value_present_i = 1'b0;
  logic [2:0] entry_slot_i = '0;
  logic signed [15:0] entry_key_i = '0, lookup_value_i = '0;
  logic [7:0] entry_red_i = '0, entry_green_i = '0, entry_blue_i = '0, entry_alpha_i = '0;
  logic out_valid_o, out_stall_i = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic from_default_o;

  ramp_scoreboard board = new();
  longint cycles = 0;
  bit stall_bursty = 0;

  color_ramp_lookup dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Check each output transfer and choose the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result('{out_red_o, out_green_o, out_blue_o, out_alpha_o, from_default_o});
    if ($urandom_range(0, 199) == 0) stall_bursty <= !stall_bursty;
    out_stall_i <= stall_bursty ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Keep valid high across back-to-back items; the caller lowers it in gaps.
  task automatic send(logic cmd, logic [2:0] slot, logic signed [15:0] key,
                      logic [31:0] col, logic signed [15:0] val, logic present);
    in_valid_i <= 1'b1; cmd_i <= cmd; entry_slot_i <= slot; entry_key_i <= key;
    {entry_red_i, entry_green_i, entry_blue_i, entry_alpha_i} <= col;
    lookup_value_i <= val; value_present_i <= present;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(cmd, slot, key, col, val, present);
  endtask

  task automatic idle_gap(int n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Load n entries with ascending keys, then lower valid.
  task automatic load_table(int n, bit tight);
    int k;
    k = tight ? $urandom_range(32768 - 2 * n, 0) - 32768 : $urandom_range(0, 20000) - 32768;
    for (int s = 0; s < n; s++) begin
      send(crl_pkg::CmdWrite, 3'(s), 16'(k), $urandom, 16'($urandom),
           1'($urandom_range(0, 1)));
      k += tight ? $urandom_range(1, 2) : $urandom_range(1, 45000 / n);
      if (k > 32767) k = 32767 - (n - 1 - s);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic lookup(logic signed [15:0] v, logic present);
    send(crl_pkg::CmdLookup, 3'($urandom), 16'($urandom), $urandom, v, present);
  endtask

  initial begin
    int n, burst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, absent value, extremes, both modes.
    write_reg(crl_pkg::CfgDefault, 32'hdeadbeef);
    lookup(16'sh0000, 1'b1);
    lookup(16'sh7fff, 1'b0);
    in_valid_i <= 1'b0;
    drain();
    send(crl_pkg::CmdWrite, 3'd0, -16'sd32768, 32'h00000000, 16'sd0, 1'b0);
    send(crl_pkg::CmdWrite, 3'd1, 16'sd0, 32'hffffffff, 16'sd0, 1'b0);
    send(crl_pkg::CmdWrite, 3'd2, 16'sd32767, 32'h10ff80f0, 16'sd0, 1'b0);
    send(crl_pkg::CmdWrite, 3'd7, 16'sd5, 32'h0102a4ff, 16'sd0, 1'b0);
    in_valid_i <= 1'b0;
    for (int m = 1; m >= 0; m--) begin
      write_reg(crl_pkg::CfgMode, 32'(m));
      write_reg(crl_pkg::CfgCount, 32'd3);
      lookup(-16'sd32768, 1'b1);
      lookup(-16'sd1, 1'b1);
      lookup(16'sd0, 1'b1);
      lookup(16'sd16384, 1'b1);
      lookup(16'sd32766, 1'b1);
      lookup(16'sd32767, 1'b1);
      lookup(16'sd100, 1'b0);
      in_valid_i <= 1'b0;
      drain();
    end
    write_reg(crl_pkg::CfgCount, 32'd15);
    write_reg(crl_pkg::CfgDefault, 32'h00000000);
    send(crl_pkg::CmdWrite, 3'd3, 16'sd32767, 32'h55aa55aa, 16'sd0, 1'b0);
    send(crl_pkg::CmdWrite, 3'd4, 16'sd32767, 32'haa55aa55, 16'sd0, 1'b0);
    send(crl_pkg::CmdWrite, 3'd5, 16'sd32767, 32'h00ff00ff, 16'sd0, 1'b0);
    send(crl_pkg::CmdWrite, 3'd6, 16'sd32767, 32'hff00ff00, 16'sd0, 1'b0);
    send(crl_pkg::CmdWrite, 3'd7, 16'sd32767, 32'h12345678, 16'sd0, 1'b0);
    lookup(16'sd32767, 1'b1);
    lookup(-16'sd32768, 1'b1);
    in_valid_i <= 1'b0;
    drain();

    // Random phases: reload a table, set registers, stream mostly lookups.
    for (int ph = 0; ph < 12; ph++) begin
      n = $urandom_range(1, 8);
      load_table(n, ph % 3 == 0);
      write_reg(crl_pkg::CfgMode, $urandom_range(0, 1));
      write_reg(crl_pkg::CfgCount, (ph == 5) ? 0 : (ph == 7 ? $urandom_range(n, 15) : n));
      write_reg(crl_pkg::CfgDefault, $urandom);
      for (int it = 0; it < 40; it++) begin
        burst = $urandom_range(0, 3);
        if (it == 20 && ph == 2) begin
          in_valid_i <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk_i);
        end
        if (it % 10 < 3) idle_gap(0);
        else idle_gap(burst == 0 ? $urandom_range(1, 4) : 0);
        if ($urandom_range(0, 19) == 0)
          send(crl_pkg::CmdWrite, 3'($urandom_range(0, 7)) | 3'(n), 16'($urandom), $urandom,
               16'sd0, 1'b0);
        else
          lookup(16'($urandom), $urandom_range(0, 9) != 0);
      end
      in_valid_i <= 1'b0;
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
